// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for the concurrent checks of the decimal ALU.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bfpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Decimal ALU package
// Commands, the per-request control record and small digit helpers.
// ---------------------------------------------------------------------------
package bfpa_pkg;

  localparam int DIGITS_DEF = 16;
  localparam int ACC_W      = 7;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_CMP = 2'd3;

  localparam logic [3:0] FRAC_RST = 4'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic       neg;
    logic       add_chk;
    logic       lt;
    logic       eq;
  } meta_t;

  function automatic logic [3:0] div10(input logic [ACC_W-1:0] x);
    logic [17:0] p;
    begin
      p = 18'(x) * 18'd205;
      div10 = p[14:11];
    end
  endfunction

  function automatic logic [3:0] clamp_digit(input logic [3:0] n);
    begin
      clamp_digit = (n > 4'd9) ? 4'd9 : n;
    end
  endfunction

endpackage

// ===== sv/bfpa_front.sv =====
// ---------------------------------------------------------------------------
// Decimal ALU entry stage
// Cleans the operands, resolves signs and comparison, and seeds the
// digit accumulator for addition and subtraction.
// ---------------------------------------------------------------------------
module bfpa_front
  import bfpa_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [1:0]              command,
  input  logic [63:0]             a_digits,
  input  logic                    a_neg,
  input  logic [63:0]             b_digits,
  input  logic                    b_neg,
  output logic [4*DIGITS-1:0]     a_r,
  output logic [4*DIGITS-1:0]     b_r,
  output logic [2*DIGITS*ACC_W-1:0] acc_r,
  output meta_t                   meta_r
);

  logic [4*DIGITS-1:0]       da, db, big, sml;
  logic [2*DIGITS*ACC_W-1:0] acc_nxt;
  meta_t                     meta_nxt;
  logic                      na, nb, nbe, a_ge, same, is_arith;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      da[4*i +: 4] = clamp_digit(a_digits[4*i +: 4]);
      db[4*i +: 4] = clamp_digit(b_digits[4*i +: 4]);
    end
    na       = a_neg && (da != '0);
    nb       = b_neg && (db != '0);
    nbe      = (command == CMD_SUB) ? (!nb && (db != '0)) : nb;
    a_ge     = (da >= db);
    same     = (na == nbe);
    is_arith = (command == CMD_ADD) || (command == CMD_SUB);
    big      = a_ge ? da : db;
    sml      = a_ge ? db : da;
    acc_nxt  = '0;
    if (is_arith) begin
      for (int i = 0; i < DIGITS; i++) begin
        if (same) begin
          acc_nxt[ACC_W*i +: ACC_W] = ACC_W'(da[4*i +: 4]) + ACC_W'(db[4*i +: 4]);
        end else begin
          acc_nxt[ACC_W*i +: ACC_W] = ACC_W'(big[4*i +: 4]) + ACC_W'(4'd9 - sml[4*i +: 4]);
        end
      end
      if (!same) begin
        acc_nxt[ACC_W-1:0] = acc_nxt[ACC_W-1:0] + ACC_W'(1);
      end
    end
    meta_nxt.cmd     = command;
    meta_nxt.add_chk = is_arith && same;
    if (command == CMD_MUL) begin
      meta_nxt.neg = na ^ nb;
    end else if (is_arith) begin
      meta_nxt.neg = (same || a_ge) ? na : nbe;
    end else begin
      meta_nxt.neg = 1'b0;
    end
    meta_nxt.eq = (command == CMD_CMP) && (da == db) && (na == nb);
    if (command != CMD_CMP) begin
      meta_nxt.lt = 1'b0;
    end else if (na != nb) begin
      meta_nxt.lt = na;
    end else begin
      meta_nxt.lt = na ? (da > db) : (da < db);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= da;
      b_r    <= db;
      acc_r  <= acc_nxt;
      meta_r <= meta_nxt;
    end
  end

endmodule

// ===== sv/bfpa_cell.sv =====
// ---------------------------------------------------------------------------
// Decimal ALU multiply cell
// Adds one multiplier digit's partial product, if any, into the redundant
// digit accumulator while moving every position's tens over by one place.
// ---------------------------------------------------------------------------
module bfpa_cell
  import bfpa_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF,
  parameter int J      = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [4*DIGITS-1:0]       a_i,
  input  logic [4*DIGITS-1:0]       b_i,
  input  logic [2*DIGITS*ACC_W-1:0] acc_i,
  input  meta_t                     meta_i,
  output logic [4*DIGITS-1:0]       a_r,
  output logic [4*DIGITS-1:0]       b_r,
  output logic [2*DIGITS*ACC_W-1:0] acc_r,
  output meta_t                     meta_r
);

  localparam int P = 2 * DIGITS;

  logic [3:0]                m;
  logic [3:0]                q [P];
  logic [2*DIGITS*ACC_W-1:0] acc_nxt;

  if (J < DIGITS) begin : g_mul
    assign m = (meta_i.cmd == CMD_MUL) ? b_i[4*J +: 4] : 4'd0;
  end else begin : g_norm
    assign m = 4'd0;
  end

  always_comb begin
    for (int p = 0; p < P; p++) begin
      q[p] = div10(acc_i[ACC_W*p +: ACC_W]);
    end
    for (int p = 0; p < P; p++) begin
      logic [ACC_W-1:0] v;
      v = acc_i[ACC_W*p +: ACC_W] - ACC_W'(q[p] * 4'd10);
      if (p > 0) begin
        v = v + ACC_W'(q[p-1]);
      end
      if ((p >= J) && (p - J < DIGITS)) begin
        v = v + ACC_W'(a_i[4*(p-J) +: 4] * m);
      end
      acc_nxt[ACC_W*p +: ACC_W] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_i;
      b_r    <= b_i;
      acc_r  <= acc_nxt;
      meta_r <= meta_i;
    end
  end

endmodule

// ===== sv/bfpa_resolve.sv =====
// ---------------------------------------------------------------------------
// Decimal ALU carry resolve and output stage
// Resolves the remaining single carries by a parallel prefix, then
// aligns the fraction, sets the flags and registers the result.
// ---------------------------------------------------------------------------
module bfpa_resolve
  import bfpa_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      en_a,
  input  logic                      en_b,
  input  logic [2*DIGITS*ACC_W-1:0] acc_i,
  input  meta_t                     meta_i,
  input  logic [3:0]                frac,
  output logic [4*DIGITS-1:0]       rd_r,
  output logic                      neg_r,
  output logic                      ovf_r,
  output logic                      lt_r,
  output logic                      eq_r
);

  localparam int P  = 2 * DIGITS;
  localparam int LV = $clog2(P);

  logic [P-1:0]   gg [LV+1];
  logic [P-1:0]   pp [LV+1];
  logic [4*P-1:0] res_nxt, res_r, sh, hi;
  meta_t          meta_a_r;
  logic [4:0]     s;
  logic [6:0]     sh_amt, hi_amt;
  logic [4*DIGITS-1:0] rd_nxt;
  logic           ovf_nxt;

  always_comb begin
    for (int i = 0; i < P; i++) begin
      gg[0][i] = acc_i[ACC_W*i +: ACC_W] >= ACC_W'(10);
      pp[0][i] = acc_i[ACC_W*i +: ACC_W] == ACC_W'(9);
    end
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < P; i++) begin
        if (i >= (1 << l)) begin
          gg[l+1][i] = gg[l][i] | (pp[l][i] & gg[l][i-(1<<l)]);
          pp[l+1][i] = pp[l][i] & pp[l][i-(1<<l)];
        end else begin
          gg[l+1][i] = gg[l][i];
          pp[l+1][i] = pp[l][i];
        end
      end
    end
    for (int i = 0; i < P; i++) begin
      logic [ACC_W-1:0] t;
      t = acc_i[ACC_W*i +: ACC_W];
      if (i > 0) begin
        t = t + ACC_W'(gg[LV][i-1]);
      end
      if (t >= ACC_W'(10)) begin
        t = t - ACC_W'(10);
      end
      res_nxt[4*i +: 4] = t[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      res_r    <= res_nxt;
      meta_a_r <= meta_i;
    end
  end

  always_comb begin
    if (meta_a_r.cmd != CMD_MUL) begin
      s = 5'd0;
    end else if (32'(frac) > DIGITS) begin
      s = 5'(DIGITS);
    end else begin
      s = 5'(frac);
    end
    sh_amt  = {s, 2'b00};
    hi_amt  = 7'({s, 2'b00} + 7'(4 * DIGITS));
    sh      = res_r >> sh_amt;
    hi      = res_r >> hi_amt;
    rd_nxt  = sh[4*DIGITS-1:0];
    ovf_nxt = 1'b0;
    if (meta_a_r.cmd == CMD_MUL) begin
      ovf_nxt = (hi != '0);
    end else if (meta_a_r.add_chk) begin
      ovf_nxt = (res_r[4*P-1:4*DIGITS] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      rd_r  <= rd_nxt;
      neg_r <= meta_a_r.neg && (rd_nxt != '0);
      ovf_r <= ovf_nxt;
      lt_r  <= meta_a_r.lt;
      eq_r  <= meta_a_r.eq;
    end
  end

endmodule

// ===== sv/bcd_fixed_point_alu.sv =====
// Throughput: one request per cycle while out_tready is high; each stage
// holds one request and moves on whenever the stage after it is empty or
// moving, so bubbles close up. The depth is set by the chain of multiply
// cells, one per multiplier digit plus one final cell that only normalises.
// Reset: synchronous, active low; clears all valid bits and sets frac_digits to 4.
// ---------------------------------------------------------------------------
// Decimal fixed-point ALU
// Sign-magnitude add, subtract, multiply and compare on packed BCD numbers.
// ---------------------------------------------------------------------------
module bcd_fixed_point_alu
  import bfpa_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,   // frac_digits
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[1:0], a_digits[65:2], a_neg[66], b_digits[130:67], b_neg[131], zeros
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_digits[63:0], result_sign[64], overflow[65], less[66], equal[67], zeros
  output logic [71:0]  out_tdata
);

  `include "assert_macros.svh"

  localparam int NC = DIGITS + 1;
  localparam int NS = DIGITS + 4;

  logic [3:0]   frac_r;
  logic [NS-1:0] v_r;
  logic [NS:0]  en;

  logic [4*DIGITS-1:0]       a_s   [NC+1];
  logic [4*DIGITS-1:0]       b_s   [NC+1];
  logic [2*DIGITS*ACC_W-1:0] acc_s [NC+1];
  meta_t                     meta_s[NC+1];

  logic [4*DIGITS-1:0] rd;
  logic                neg, ovf, lt, eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RST;
    end else if (cfg_wr_en) begin
      frac_r <= cfg_wr_data;
    end
  end

  always_comb begin
    en[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  bfpa_front #(.DIGITS(DIGITS)) u_front (
    .clk      (clk),
    .en       (en[0]),
    .command  (in_tdata[1:0]),
    .a_digits (in_tdata[65:2]),
    .a_neg    (in_tdata[66]),
    .b_digits (in_tdata[130:67]),
    .b_neg    (in_tdata[131]),
    .a_r      (a_s[0]),
    .b_r      (b_s[0]),
    .acc_r    (acc_s[0]),
    .meta_r   (meta_s[0])
  );

  for (genvar j = 0; j < NC; j++) begin : g_cell
    bfpa_cell #(.DIGITS(DIGITS), .J(j)) u_cell (
      .clk    (clk),
      .en     (en[j+1]),
      .a_i    (a_s[j]),
      .b_i    (b_s[j]),
      .acc_i  (acc_s[j]),
      .meta_i (meta_s[j]),
      .a_r    (a_s[j+1]),
      .b_r    (b_s[j+1]),
      .acc_r  (acc_s[j+1]),
      .meta_r (meta_s[j+1])
    );
  end

  bfpa_resolve #(.DIGITS(DIGITS)) u_resolve (
    .clk    (clk),
    .en_a   (en[NS-2]),
    .en_b   (en[NS-1]),
    .acc_i  (acc_s[NC]),
    .meta_i (meta_s[NC]),
    .frac   (frac_r),
    .rd_r   (rd),
    .neg_r  (neg),
    .ovf_r  (ovf),
    .lt_r   (lt),
    .eq_r   (eq)
  );

  assign out_tdata = {4'b0000, eq, lt, ovf, neg, 64'(rd)};

  `ASSERT_IMPLIES(a_neg_nonzero, out_tvalid && out_tdata[64], out_tdata[63:0] != 64'd0,
    "negative zero result")
  `ASSERT_IMPLIES(a_cmp_clean, out_tvalid && (out_tdata[66] || out_tdata[67]),
    !out_tdata[64] && !out_tdata[65] && (out_tdata[63:0] == 64'd0),
    "compare result carries arithmetic fields")
  `ASSERT_IMPLIES(a_lt_eq_excl, out_tvalid, !(out_tdata[66] && out_tdata[67]),
    "less and equal both set")
  `ASSERT_IMPLIES(a_stall_only_full, !in_tready, out_tvalid && !out_tready,
    "input stalled while output side can drain")
  `ASSERT_NEXT(a_hold_drains, out_tvalid && out_tready && !v_r[NS-2], !out_tvalid,
    "result repeated after delivery")

endmodule

// ===== bench/bcd_fixed_point_alu_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decimal fixed-point ALU testbench
// Sends add, subtract, multiply and compare requests over the input stream,
// predicts each result from the operands and the fraction digit count, and
// compares every result field with the oldest prediction.
// ---------------------------------------------------------------------------
module bcd_fixed_point_alu_tb;
  import bfpa_pkg::*;

  localparam int ND = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic       equal;
    logic       less;
    logic       overflow;
    logic       neg;
    logic [63:0] digits;
  } alu_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [3:0]   cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  logic [3:0]   frac_setting;
  alu_result_t  pending_results[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           rx_wait = 0;
  bit           rx_random = 1'b1;

  bcd_fixed_point_alu dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void unpack_bcd(input logic [63:0] p, output int unsigned d[ND],
                                     output longint unsigned v);
    v = 0;
    for (int i = 0; i < ND; i++) d[i] = (p[4*i +: 4] > 9) ? 9 : p[4*i +: 4];
    for (int i = ND - 1; i >= 0; i--) v = v * 10 + d[i];
  endfunction

  function automatic logic [63:0] pack_bcd(input longint unsigned v);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < ND; i++) begin
      p[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return p;
  endfunction

  function automatic alu_result_t compute_alu(input logic [1:0] cmd, input logic [63:0] a,
                                              input logic an, input logic [63:0] b,
                                              input logic bn, input logic [3:0] frac);
    alu_result_t r;
    int unsigned da[ND], db[ND], pr[2*ND];
    longint unsigned va, vb, mag, lim;
    logic na, nb;
    r = '0;
    unpack_bcd(a, da, va);
    unpack_bcd(b, db, vb);
    na = an && va != 0;
    nb = bn && vb != 0;
    lim = 64'd10000000000000000;
    if (cmd == CMD_CMP) begin
      r.equal = (va == vb) && (na == nb);
      if (na != nb) r.less = na;
      else r.less = na ? (va > vb) : (va < vb);
    end else if (cmd == CMD_MUL) begin
      for (int i = 0; i < 2*ND; i++) pr[i] = 0;
      for (int i = 0; i < ND; i++)
        for (int j = 0; j < ND; j++) pr[i+j] += da[i] * db[j];
      for (int i = 0; i + 1 < 2*ND; i++) begin
        pr[i+1] += pr[i] / 10;
        pr[i] = pr[i] % 10;
      end
      for (int i = 0; i < ND; i++) r.digits[4*i +: 4] = 4'(pr[frac + i]);
      for (int i = frac + ND; i < 2*ND; i++) if (pr[i] != 0) r.overflow = 1'b1;
      r.neg = (na != nb) && r.digits != 0;
    end else begin
      if (cmd == CMD_SUB) nb = !nb && vb != 0;
      if (na == nb) begin
        mag = va + vb;
        if (mag >= lim) begin
          mag -= lim;
          r.overflow = 1'b1;
        end
        r.neg = na;
      end else if (va >= vb) begin
        mag = va - vb;
        r.neg = na;
      end else begin
        mag = vb - va;
        r.neg = nb;
      end
      if (mag == 0) r.neg = 1'b0;
      r.digits = pack_bcd(mag);
    end
    return r;
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [63:0] a, input logic an,
                              input logic [63:0] b, input logic bn);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, bn, b, an, a, cmd};
    pending_results.insert(pending_results.size(),
                           compute_alu(cmd, a, an, b, bn, frac_setting));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_frac(input logic [3:0] f);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frac_setting = f;
  endtask

  function automatic logic [63:0] random_bcd(input int span);
    logic [63:0] p;
    int n;
    p = '0;
    n = $urandom_range(1, span);
    for (int i = 0; i < n; i++) p[4*i +: 4] = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 15) == 0) p = {$urandom, $urandom};
    return p;
  endfunction

  task automatic test_directed();
    logic [63:0] nines;
    nines = 64'h9999_9999_9999_9999;
    send_request(CMD_ADD, nines, 1'b0, 64'h1, 1'b0);
    send_request(CMD_ADD, nines, 1'b1, nines, 1'b1);
    send_request(CMD_SUB, 64'h5, 1'b0, 64'h5, 1'b0);
    send_request(CMD_SUB, 64'h3, 1'b0, 64'h7, 1'b0);
    send_request(CMD_SUB, 64'h3, 1'b1, 64'h7, 1'b1);
    send_request(CMD_ADD, 64'h0, 1'b1, 64'h0, 1'b1);
    send_request(CMD_SUB, 64'h0, 1'b0, 64'h0, 1'b1);
    send_request(CMD_MUL, nines, 1'b0, nines, 1'b1);
    send_request(CMD_MUL, 64'h0, 1'b1, nines, 1'b0);
    send_request(CMD_MUL, 64'h12345, 1'b1, 64'h20000, 1'b1);
    send_request(CMD_CMP, 64'h0, 1'b1, 64'h0, 1'b0);
    send_request(CMD_CMP, 64'h5, 1'b1, 64'h3, 1'b1);
    send_request(CMD_CMP, 64'h3, 1'b0, 64'h5, 1'b0);
    send_request(CMD_CMP, 64'h3, 1'b0, 64'h3, 1'b1);
    send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'hABCD_EF00_0000_0000, 1'b0);
    send_request(CMD_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hF, 1'b0);
    send_request(CMD_CMP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, nines, 1'b1);
    send_request(CMD_SUB, '0, 1'b1, nines, 1'b1);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_request(2'($urandom_range(0, 3)), random_bcd(16), 1'($urandom),
                   random_bcd(16), 1'($urandom));
  endtask

  task automatic test_frac_settings();
    logic [3:0] settings[5] = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd4};
    foreach (settings[k]) begin
      write_frac(settings[k]);
      send_request(CMD_MUL, 64'h9999_9999_9999_9999, 1'b0, 64'h9999_9999_9999_9999, 1'b0);
      send_request(CMD_MUL, 64'h1, 1'b0, 64'h1, 1'b1);
      test_random(200);
    end
  endtask

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        w = rx_random ? $urandom_range(0, 16) : 0;
        out_tready <= (w == 0);
        rx_wait <= w;
      end
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alu_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = alu_result_t'(out_tdata[67:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected digits %h neg %b ovf %b lt %b eq %b", $time,
                   want.digits, want.neg, want.overflow, want.less, want.equal);
          $display("%0t:          actual digits %h neg %b ovf %b lt %b eq %b", $time,
                   got.digits, got.neg, got.overflow, got.less, got.equal);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bcd_fixed_point_alu regression: fail");
      $finish;
    end
  end

  initial begin
    frac_setting = FRAC_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    rx_random = 1'b0;
    test_random(120);
    wait_drained();
    rx_random = 1'b1;
    test_frac_settings();
    wait_drained();
    if (error_count == 0) $display("bcd_fixed_point_alu regression: pass");
    else $display("bcd_fixed_point_alu regression: fail");
    $finish;
  end
endmodule
